[hdl/u8val_pkg.sv]
// ----------------------------------------------------------------------------
// u8val_pkg
// Constants shared by the UTF-8 character validator and its checker.
// ----------------------------------------------------------------------------
package u8val_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_ALLOW_ASCII_CONTROLS = 3'h0;

    localparam logic [7:0] BYTE_NUL      = 8'h00;
    localparam logic [7:0] BYTE_TAB      = 8'h09;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] PRINT_LO      = 8'h20;
    localparam logic [7:0] PRINT_HI      = 8'h7E;
    localparam logic [7:0] ASCII_HI      = 8'h7F;
    localparam logic [7:0] LEAD2_LO      = 8'hC2;
    localparam logic [7:0] LEAD2_HI      = 8'hDF;
    localparam logic [7:0] LEAD3_LO      = 8'hE0;
    localparam logic [7:0] LEAD3_HI      = 8'hEF;
    localparam logic [7:0] LEAD4_LO      = 8'hF0;
    localparam logic [7:0] LEAD4_HI      = 8'hF4;
    localparam logic [7:0] LEAD_E0       = 8'hE0;
    localparam logic [7:0] LEAD_ED       = 8'hED;
    localparam logic [7:0] LEAD_F0       = 8'hF0;
    localparam logic [7:0] LEAD_F4       = 8'hF4;
    localparam logic [7:0] CONT_LO       = 8'h80;
    localparam logic [7:0] CONT_HI       = 8'hBF;
    localparam logic [7:0] CONT_E0_LO    = 8'hA0;
    localparam logic [7:0] CONT_ED_HI    = 8'h9F;
    localparam logic [7:0] CONT_F0_LO    = 8'h90;
    localparam logic [7:0] CONT_F4_HI    = 8'h8F;

    localparam logic [2:0] MAX_CHAR_LEN  = 3'd4;

endpackage

[hdl/utf8_char_validator.sv]
// ----------------------------------------------------------------------------
// utf8_char_validator
// Strict UTF-8 character checker that takes one text byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
// Text bytes enter on text_valid/text_byte and are accepted at a rising edge
// where text_valid is high and text_stall is low. One result transaction,
// char_ok and char_len, leaves on char_valid/char_stall when a character
// completes, when an error is found, or when a NUL byte arrives while idle.
// Bytes inside a multi-byte character produce no result.
// A byte is held in an input register, checked by the decode logic and the
// result is captured in an output register when the byte leaves the input
// register; that byte can wait there while the output register is stalled.
// One byte is accepted every cycle while the receiver takes results; the
// output register separates the two sides.
// When the receiver stalls, the result is held and the pending byte waits in
// the input register; text_stall rises only when that byte would produce a
// result and the output register is still occupied.
// Reset empties both registers, returns the checker to idle and clears
// allow_ascii_controls. That register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module utf8_char_validator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                text_valid,
    output logic                                text_stall,
    input  logic [7:0]                          text_byte,
    output logic                                char_valid,
    input  logic                                char_stall,
    output logic                                char_ok,
    output logic [2:0]                          char_len,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [u8val_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [u8val_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [u8val_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import u8val_pkg::*;

    logic       allow_ctrl_reg;
    logic       byte_valid_reg;
    logic       byte_valid_next;
    logic [7:0] byte_reg;
    logic [1:0] need_reg;
    logic [1:0] need_next;
    logic [2:0] taken_reg;
    logic [2:0] taken_next;
    logic [7:0] lead_reg;
    logic [7:0] lead_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       res_ok_reg;
    logic [2:0] res_len_reg;

    logic       produce;
    logic       res_ok;
    logic [2:0] res_len;
    logic       advance;
    logic       res_free;
    logic       text_accept;
    logic       ascii_ok;
    logic       cont_ok;
    logic [7:0] cont_lo;
    logic [7:0] cont_hi;
    logic [2:0] taken_inc;

    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_W-1){1'b0}}, allow_ctrl_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_ctrl_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[APB_ADDR_W-1:2] == REG_ALLOW_ASCII_CONTROLS[APB_ADDR_W-1:2]))
        begin
            allow_ctrl_reg <= pwdata[0];
        end
    end

    assign ascii_ok = allow_ctrl_reg ||
                      (byte_reg == BYTE_TAB) || (byte_reg == BYTE_LF) ||
                      (byte_reg == BYTE_CR) ||
                      ((byte_reg >= PRINT_LO) && (byte_reg <= PRINT_HI));

    always_comb
    begin
        cont_lo = CONT_LO;
        cont_hi = CONT_HI;
        if (taken_reg == 3'd1)
        begin
            unique case (lead_reg)
                LEAD_E0: cont_lo = CONT_E0_LO;
                LEAD_ED: cont_hi = CONT_ED_HI;
                LEAD_F0: cont_lo = CONT_F0_LO;
                LEAD_F4: cont_hi = CONT_F4_HI;
                default: ;
            endcase
        end
    end

    assign cont_ok   = (byte_reg >= cont_lo) && (byte_reg <= cont_hi);
    assign taken_inc = taken_reg + 3'd1;

    always_comb
    begin
        produce    = 1'b0;
        res_ok     = 1'b0;
        res_len    = 3'd0;
        need_next  = 2'd0;
        taken_next = 3'd0;
        lead_next  = 8'h00;
        if (need_reg == 2'd0)
        begin
            if (byte_reg == BYTE_NUL)
            begin
                produce = 1'b1;
            end
            else if (byte_reg <= ASCII_HI)
            begin
                produce = 1'b1;
                res_ok  = ascii_ok;
                res_len = 3'd1;
            end
            else if ((byte_reg >= LEAD2_LO) && (byte_reg <= LEAD2_HI))
            begin
                need_next  = 2'd1;
                taken_next = 3'd1;
                lead_next  = byte_reg;
            end
            else if ((byte_reg >= LEAD3_LO) && (byte_reg <= LEAD3_HI))
            begin
                need_next  = 2'd2;
                taken_next = 3'd1;
                lead_next  = byte_reg;
            end
            else if ((byte_reg >= LEAD4_LO) && (byte_reg <= LEAD4_HI))
            begin
                need_next  = 2'd3;
                taken_next = 3'd1;
                lead_next  = byte_reg;
            end
            else
            begin
                produce = 1'b1;
                res_len = 3'd1;
            end
        end
        else if (byte_reg == BYTE_NUL)
        begin
            produce = 1'b1;
            res_len = taken_reg;
        end
        else if (!cont_ok)
        begin
            produce = 1'b1;
            res_len = taken_inc;
        end
        else if (need_reg == 2'd1)
        begin
            produce = 1'b1;
            res_ok  = 1'b1;
            res_len = taken_inc;
        end
        else
        begin
            need_next  = need_reg - 2'd1;
            taken_next = taken_inc;
            lead_next  = lead_reg;
        end
    end

    assign res_free    = !res_valid_reg || !char_stall;
    assign advance     = byte_valid_reg && (!produce || res_free);
    assign text_stall  = byte_valid_reg && !advance;
    assign text_accept = text_valid && !text_stall;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (text_accept)
        begin
            byte_valid_next = 1'b1;
        end
        else if (advance)
        begin
            byte_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance && produce)
        begin
            res_valid_next = 1'b1;
        end
        else if (!char_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            need_reg       <= 2'd0;
            taken_reg      <= 3'd0;
            lead_reg       <= 8'h00;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            res_valid_reg  <= res_valid_next;
            if (advance)
            begin
                need_reg  <= need_next;
                taken_reg <= taken_next;
                lead_reg  <= lead_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            byte_reg <= text_byte;
        end
        if (advance && produce)
        begin
            res_ok_reg  <= res_ok;
            res_len_reg <= res_len;
        end
    end

    assign char_valid = res_valid_reg;
    assign char_ok    = res_ok_reg;
    assign char_len   = res_len_reg;

endmodule

[hdl/u8val_checker.sv]
// ----------------------------------------------------------------------------
// u8val_checker
// Port-level checks for the UTF-8 character validator.
// ----------------------------------------------------------------------------
module u8val_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_stall,
    input logic       char_ok,
    input logic [2:0] char_len,
    input logic       pready
);
    import u8val_pkg::*;

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_len <= MAX_CHAR_LEN))
        else $error("result length out of range");

    a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_ok) |-> (char_len != 3'd0))
        else $error("valid character with zero length");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_stall) |=>
            (char_valid && $stable(char_ok) && $stable(char_len)))
        else $error("stalled result changed");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind utf8_char_validator u8val_checker u_u8val_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_ok    (char_ok),
    .char_len   (char_len),
    .pready     (pready)
);
